>>> hdl/bfgiv_pkg.sv
// ============================================================================
// bfgiv_pkg
// Shared types, register indexes and mode codes for the bfloat16
// modified Givens apply unit.
// ============================================================================
package bfgiv_pkg;

   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 16;

   localparam logic [CsrIdxWidth-1:0] CSR_MODE = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_H11  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_H12  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_H21  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_H22  = 3'd4;

   localparam logic [1:0] MODE_FULL    = 2'd0;
   localparam logic [1:0] MODE_UNIT_DG = 2'd1;
   localparam logic [1:0] MODE_UNIT_OD = 2'd2;
   localparam logic [1:0] MODE_IDENT   = 2'd3;

   localparam logic [15:0] BF_ONE  = 16'h3F80;
   localparam logic [15:0] BF_MONE = 16'hBF80;
   localparam logic [15:0] BF_QNAN = 16'h7FC0;

   typedef struct packed {
      logic [15:0] x_value;
      logic [15:0] y_value;
      logic        last_pair;
   } req_type;

   typedef struct packed {
      logic [15:0] x_result;
      logic [15:0] y_result;
      logic        last_pair_out;
   } rsp_type;

   // unpacked floating value: class flags, sign, exponent, significand
   typedef struct packed {
      logic        nan;
      logic        inf;
      logic        zero;
      logic        sign;
      logic signed [10:0] exp;
      logic [15:0] sig;
   } prod_type;

   // Round a positive value sig * 2^(exp - 15) (sig normalized with msb at bit 15
   // or zero) to bfloat16 with round to nearest even, subnormals kept.
   function automatic logic [15:0] bf_round(input logic sign,
                                            input logic signed [10:0] exp,
                                            input logic [15:0] sig,
                                            input logic sticky);
      logic [4:0]  shift;
      logic [24:0] ext;
      logic [24:0] shifted;
      logic        stk;
      logic [8:0]  q;
      logic        g;
      logic        rb;
      logic [15:0] r;
      logic signed [11:0] bexp;
      ext   = {sig, 8'd0, sticky};
      bexp  = 12'(exp) + 12'sd127;
      shift = 5'd0;
      if (bexp < 12'sd1) begin
         if (bexp < -12'sd20) shift = 5'd22;
         else shift = 5'(12'sd1 - bexp);
         bexp = 12'sd0;
      end
      shifted = ext >> shift;
      stk = |(ext & ~({25{1'b1}} << shift));
      q  = {1'b0, shifted[24:17]};
      g  = shifted[16];
      rb = (|shifted[15:0]) | stk;
      if (g && (rb || q[0])) q = q + 9'd1;
      if (bexp == 12'sd0) begin
         r = {sign, 7'd0, q[7:0]};
         if (q[8]) r = {sign, 8'd1, 7'd0};
         else if (q[7]) r = {sign, 8'd1, q[6:0]};
      end else begin
         if (q[8]) begin
            bexp = bexp + 12'sd1;
            q = 9'h080;
         end
         if (bexp >= 12'sd255) r = {sign, 15'h7F80};
         else r = {sign, bexp[7:0], q[6:0]};
      end
      if (sig == 16'd0) r = {sign, 15'd0};
      return r;
   endfunction

endpackage

>>> hdl/bfgiv_mul.sv
// ============================================================================
// bfgiv_mul
// Registered bfloat16 multiplier with round to nearest even.
// ============================================================================
module bfgiv_mul
   import bfgiv_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [15:0] a,
   input  logic [15:0] b,
   output logic [15:0] p
);
   logic [15:0] p_ff;
   logic [15:0] p_in;
   logic [15:0] prod;
   logic [7:0]  ma;
   logic [7:0]  mb;
   logic signed [10:0] ea;
   logic signed [10:0] eb;
   logic [3:0]  lz_a;
   logic [3:0]  lz_b;
   logic        sg;
   logic        a_nan;
   logic        b_nan;
   logic        a_inf;
   logic        b_inf;
   logic        a_zero;
   logic        b_zero;
   logic [15:0] norm;
   logic signed [10:0] e;

   always_comb begin
      a_nan  = (a[14:7] == 8'hFF) && (a[6:0] != 7'd0);
      b_nan  = (b[14:7] == 8'hFF) && (b[6:0] != 7'd0);
      a_inf  = (a[14:7] == 8'hFF) && (a[6:0] == 7'd0);
      b_inf  = (b[14:7] == 8'hFF) && (b[6:0] == 7'd0);
      a_zero = a[14:0] == 15'd0;
      b_zero = b[14:0] == 15'd0;
      sg     = a[15] ^ b[15];
      ma = (a[14:7] == 8'd0) ? {1'b0, a[6:0]} : {1'b1, a[6:0]};
      mb = (b[14:7] == 8'd0) ? {1'b0, b[6:0]} : {1'b1, b[6:0]};
      ea = (a[14:7] == 8'd0) ? -11'sd126 : 11'(a[14:7]) - 11'sd127;
      eb = (b[14:7] == 8'd0) ? -11'sd126 : 11'(b[14:7]) - 11'sd127;
      lz_a = 4'd0;
      lz_b = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (ma[i]) lz_a = 4'(7 - i);
         if (mb[i]) lz_b = 4'(7 - i);
      end
      ma = ma << lz_a;
      mb = mb << lz_b;
      prod = ma * mb;
      e = ea + eb - 11'(lz_a) - 11'(lz_b);
      if (prod[15]) begin
         norm = prod;
         e    = e + 11'sd1;
      end else begin
         norm = {prod[14:0], 1'b0};
      end
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) p_in = BF_QNAN;
      else if (a_inf || b_inf) p_in = {sg, 15'h7F80};
      else if (a_zero || b_zero) p_in = {sg, 15'd0};
      else p_in = bf_round(sg, e, norm, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (en) p_ff <= p_in;
   end

   assign p = p_ff;
endmodule

>>> hdl/bfgiv_add.sv
// ============================================================================
// bfgiv_add
// Two-stage bfloat16 adder: align and add, then normalize and round.
// ============================================================================
module bfgiv_add
   import bfgiv_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [15:0] a,
   input  logic [15:0] b,
   output logic [15:0] s
);
   typedef struct packed {
      logic        special;
      logic [15:0] spec_val;
      logic        sign;
      logic signed [10:0] exp;
      logic [19:0] mag;
      logic        sticky;
      logic        exact_zero_neg;
   } sum_type;

   sum_type     st_ff;
   sum_type     st_in;
   logic [15:0] s_ff;
   logic [15:0] s_in;

   logic [15:0] big;
   logic [15:0] sml;
   logic [7:0]  ebig;
   logic [7:0]  esml;
   logic [7:0]  mbig;
   logic [7:0]  msml;
   logic [7:0]  d;
   logic [19:0] abig;
   logic [19:0] asml;
   logic [19:0] shifted;
   logic        stk;
   logic        a_nan;
   logic        b_nan;
   logic        a_inf;
   logic        b_inf;

   always_comb begin
      a_nan = (a[14:7] == 8'hFF) && (a[6:0] != 7'd0);
      b_nan = (b[14:7] == 8'hFF) && (b[6:0] != 7'd0);
      a_inf = (a[14:7] == 8'hFF) && (a[6:0] == 7'd0);
      b_inf = (b[14:7] == 8'hFF) && (b[6:0] == 7'd0);
      if (a[14:0] >= b[14:0]) begin
         big = a;
         sml = b;
      end else begin
         big = b;
         sml = a;
      end
      ebig = (big[14:7] == 8'd0) ? 8'd1 : big[14:7];
      esml = (sml[14:7] == 8'd0) ? 8'd1 : sml[14:7];
      mbig = {big[14:7] != 8'd0, big[6:0]};
      msml = {sml[14:7] != 8'd0, sml[6:0]};
      d    = ebig - esml;
      abig = {2'b00, mbig, 10'd0};
      asml = {2'b00, msml, 10'd0};
      if (d > 8'd19) begin
         shifted = 20'd0;
         stk     = msml != 8'd0;
      end else begin
         shifted = asml >> d[4:0];
         stk     = |(asml & ~({20{1'b1}} << d[4:0]));
      end
      st_in = '0;
      st_in.sign   = big[15];
      st_in.exp    = 11'(ebig) - 11'sd127;
      st_in.sticky = stk;
      st_in.exact_zero_neg = a[15] & b[15];
      if (a[15] == b[15]) st_in.mag = abig + shifted;
      else st_in.mag = abig - shifted - 20'(stk);
      if (a_nan || b_nan || (a_inf && b_inf && (a[15] != b[15]))) begin
         st_in.special  = 1'b1;
         st_in.spec_val = BF_QNAN;
      end else if (a_inf || b_inf) begin
         st_in.special  = 1'b1;
         st_in.spec_val = a_inf ? a : b;
      end
   end

   logic [19:0] nm;
   logic [4:0]  lz;
   logic signed [10:0] ne;

   always_comb begin
      lz = 5'd0;
      for (int i = 0; i < 20; i++) begin
         if (st_ff.mag[i]) lz = 5'(19 - i);
      end
      nm = st_ff.mag << lz;
      // value = mag * 2^(exp - 17); bf_round takes sig msb weight 2^exp
      ne = st_ff.exp + 11'sd2 - 11'(lz);
      if (st_ff.special) s_in = st_ff.spec_val;
      else if (st_ff.mag == 20'd0) s_in = {st_ff.exact_zero_neg, 15'd0};
      else s_in = bf_round(st_ff.sign, ne, nm[19:4], (|nm[3:0]) | st_ff.sticky);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
         s_ff  <= s_in;
      end
   end

   assign s = s_ff;
endmodule

>>> hdl/bf16_modified_givens_apply_unit.sv
// ============================================================================
// bf16_modified_givens_apply_unit
// Applies a modified Givens transform to a stream of bfloat16 (x, y) pairs.
// ============================================================================
// Usage:
//   req_* carries one (x, y, last) beat; rsp_* returns one transformed beat
//   per request, in order. csr_* writes mode and the four coefficients;
//   write only while no beat is in flight.
//   rsp_valid rises once a beat has passed the multiply, align and add,
//   normalize and round, and output register stages.
//   Throughput: one beat per cycle while the output is not stalled; the
//   four-stage pipeline with a valid bit per stage sets this figure.
//   Reset clears all stage valids and sets identity mode, coefficients zero.
//   When the output stage is full and rsp_ready is low the whole pipeline
//   holds; req_ready drops only then, so nothing is lost.
//   Identity passes x and y unchanged; unit modes substitute +1 or -1
//   coefficients into the shared multiply-add datapath, full mode none.
// ============================================================================
module bf16_modified_givens_apply_unit
   import bfgiv_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  logic                    csr_write,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata
);
   localparam int Depth = 4;

   logic [1:0]  mode_ff;
   logic [15:0] h11_ff;
   logic [15:0] h12_ff;
   logic [15:0] h21_ff;
   logic [15:0] h22_ff;
   logic [Depth-1:0] vld_ff;
   logic [Depth-1:0] vld_in;
   logic [Depth-1:0] last_ff;
   logic [Depth-1:0] iden_ff;
   logic [15:0] px_ff [Depth-1];
   logic [15:0] py_ff [Depth-1];
   logic        adv;
   logic [15:0] c11;
   logic [15:0] c12;
   logic [15:0] c21;
   logic [15:0] c22;
   logic [15:0] m11;
   logic [15:0] m12;
   logic [15:0] m21;
   logic [15:0] m22;
   logic [15:0] sx;
   logic [15:0] sy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDENT;
         h11_ff  <= '0;
         h12_ff  <= '0;
         h21_ff  <= '0;
         h22_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODE: mode_ff <= csr_wdata[1:0];
            CSR_H11:  h11_ff  <= csr_wdata;
            CSR_H12:  h12_ff  <= csr_wdata;
            CSR_H21:  h21_ff  <= csr_wdata;
            CSR_H22:  h22_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      c11 = h11_ff;
      c12 = h12_ff;
      c21 = h21_ff;
      c22 = h22_ff;
      unique case (mode_ff)
         MODE_UNIT_DG: begin
            c11 = BF_ONE;
            c22 = BF_ONE;
         end
         MODE_UNIT_OD: begin
            c12 = BF_ONE;
            c21 = BF_MONE;
         end
         default: ;
      endcase
   end

   assign adv       = !vld_ff[Depth-1] || rsp_ready;
   assign req_ready = adv;

   bfgiv_mul u_m11 (.clock(clock), .en(adv), .a(req_data.x_value), .b(c11), .p(m11));
   bfgiv_mul u_m12 (.clock(clock), .en(adv), .a(req_data.y_value), .b(c12), .p(m12));
   bfgiv_mul u_m21 (.clock(clock), .en(adv), .a(req_data.x_value), .b(c21), .p(m21));
   bfgiv_mul u_m22 (.clock(clock), .en(adv), .a(req_data.y_value), .b(c22), .p(m22));
   bfgiv_add u_ax  (.clock(clock), .en(adv), .a(m11), .b(m12), .s(sx));
   bfgiv_add u_ay  (.clock(clock), .en(adv), .a(m21), .b(m22), .s(sy));

   assign vld_in = {vld_ff[Depth-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_ff <= {last_ff[Depth-2:0], req_data.last_pair};
         iden_ff <= {iden_ff[Depth-2:0], mode_ff == MODE_IDENT};
         px_ff[0] <= req_data.x_value;
         py_ff[0] <= req_data.y_value;
         for (int i = 1; i < Depth - 1; i++) begin
            px_ff[i] <= px_ff[i-1];
            py_ff[i] <= py_ff[i-1];
         end
         rsp_data.x_result      <= iden_ff[Depth-2] ? px_ff[Depth-2] : sx;
         rsp_data.y_result      <= iden_ff[Depth-2] ? py_ff[Depth-2] : sy;
         rsp_data.last_pair_out <= last_ff[Depth-2];
      end
   end

   assign rsp_valid = vld_ff[Depth-1];
endmodule

>>> hdl/bfgiv_checker.sv
// ============================================================================
// bfgiv_checker
// Port-level checks for the bfloat16 modified Givens apply unit.
// ============================================================================
module bfgiv_checker
   import bfgiv_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req taken during output stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");
endmodule

bind bf16_modified_givens_apply_unit bfgiv_checker u_bfgiv_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
